// ----- rtl/core/gctp_pkg.sv -----
// Shared constants and the CORDIC arctangent table for gravity-compensated dead reckoning.
`timescale 1ns / 1ps

package gctp_pkg;

    localparam int ACC_W      = 16;
    localparam int ANG_W      = 16;
    localparam int POS_W      = 32;
    localparam int DT_W       = 20;
    localparam int LIN_W      = 18;
    localparam int CRD_W      = 34;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ATAN_N     = 24;
    localparam int ATAN_IW    = 5;
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 96;

    localparam logic signed [CRD_W-1:0] CORDIC_K = CRD_W'(652032874);
    localparam logic signed [ANG_W-1:0] QUARTER  = ANG_W'(16384);

    function automatic logic signed [CRD_W-1:0] atan_val(input logic [ATAN_IW-1:0] idx);
        logic signed [CRD_W-1:0] v;
        case (idx)
            5'd0:  v = CRD_W'(536870912);
            5'd1:  v = CRD_W'(316933406);
            5'd2:  v = CRD_W'(167458907);
            5'd3:  v = CRD_W'(85004756);
            5'd4:  v = CRD_W'(42667331);
            5'd5:  v = CRD_W'(21354465);
            5'd6:  v = CRD_W'(10679838);
            5'd7:  v = CRD_W'(5340245);
            5'd8:  v = CRD_W'(2670163);
            5'd9:  v = CRD_W'(1335087);
            5'd10: v = CRD_W'(667544);
            5'd11: v = CRD_W'(333772);
            5'd12: v = CRD_W'(166886);
            5'd13: v = CRD_W'(83443);
            5'd14: v = CRD_W'(41722);
            5'd15: v = CRD_W'(20861);
            5'd16: v = CRD_W'(10430);
            5'd17: v = CRD_W'(5215);
            5'd18: v = CRD_W'(2608);
            5'd19: v = CRD_W'(1304);
            5'd20: v = CRD_W'(652);
            5'd21: v = CRD_W'(326);
            5'd22: v = CRD_W'(163);
            5'd23: v = CRD_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/gravity_comp_trapezoid_position_top.sv -----
// Top level of the gravity-compensated trapezoidal dead-reckoning position unit.
`timescale 1ns / 1ps

// A transaction runs from acceptance through an angle-reduction step and SINCOS_STEPS
// rotations for each of pitch and roll, the two gravity products, the integration of each
// axis and the loading of the output register. A single CORDIC rotator produces the cosine
// and sine of pitch and then of roll, and a single registered 33x33 multiplier then forms
// both gravity products and, axis by axis, the velocity and position increments. The input
// is not ready while a transaction is in flight; a finished result sits in the output
// register until it is taken, and the block returns to ready in the same cycle that the
// result is loaded there, which waits until any previous result has been taken.
module gravity_comp_trapezoid_position_top #(
    parameter int SINCOS_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // acc_x, acc_y, acc_z, pitch_angle, roll_angle, prev_pos_x, prev_pos_y, prev_pos_z,
    // time_step, zero fill.
    input  logic [gctp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pos_x, pos_y, pos_z.
    output logic [gctp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int CRD_W  = gctp_pkg::CRD_W;
    localparam int MUL_W  = gctp_pkg::MUL_W;
    localparam int PROD_W = gctp_pkg::PROD_W;
    localparam int POS_W  = gctp_pkg::POS_W;
    localparam int LIN_W  = gctp_pkg::LIN_W;
    localparam int ANG_W  = gctp_pkg::ANG_W;
    localparam int ACC_W  = gctp_pkg::ACC_W;
    localparam int DT_W   = gctp_pkg::DT_W;
    localparam int IW     = gctp_pkg::ATAN_IW;
    localparam logic [IW-1:0] LAST_IT = IW'(SINCOS_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED, ST_ROT, ST_G0W, ST_G0, ST_G2W, ST_G2,
        ST_VOP, ST_VW, ST_V, ST_PW, ST_P, ST_OUT
    } t_state;

    t_state                      r_state;
    logic [IW-1:0]               r_it;
    logic                        r_roll;
    logic [1:0]                  r_ax;
    logic signed [CRD_W-1:0]     r_x, r_y, r_z;
    logic                        r_neg;
    logic signed [MUL_W-1:0]     r_cp, r_sp, r_cr;
    logic signed [ACC_W-1:0]     r_acc [3];
    logic signed [POS_W-1:0]     r_prev [3];
    logic signed [ANG_W-1:0]     r_pitch, r_rollang;
    logic [DT_W-1:0]             r_dt;
    logic signed [LIN_W-1:0]     r_grav [3];
    logic signed [LIN_W-1:0]     r_last [3];
    logic signed [POS_W-1:0]     r_vel [3];
    logic signed [POS_W-1:0]     r_pos [3];
    logic signed [LIN_W-1:0]     r_a1;
    logic signed [POS_W-1:0]     r_v1;
    logic signed [MUL_W-1:0]     r_ma, r_mb;
    logic signed [PROD_W-1:0]    r_prod;
    logic                        r_ovalid;
    logic [gctp_pkg::OUT_TDATA_W-1:0] r_odata;

    logic signed [ANG_W-1:0]     n_ang_sel;
    logic signed [ANG_W:0]       n_ang_red;
    logic                        n_neg;
    logic signed [CRD_W-1:0]     n_x, n_y, n_z, n_xs, n_ys, n_atan;
    logic signed [CRD_W-1:0]     n_xf, n_yf;
    logic signed [PROD_W-1:0]    n_rnd48;
    logic signed [LIN_W-1:0]     n_grav1;
    logic signed [LIN_W-1:0]     n_a1;
    logic signed [LIN_W:0]       n_asum;
    logic signed [PROD_W-1:0]    n_rnd17, n_rnd21;
    logic signed [POS_W+1:0]     n_vsum, n_psum;
    logic signed [POS_W-1:0]     n_v1, n_p1;
    logic signed [POS_W:0]       n_vv;
    logic                        s_acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_ang_sel = r_roll ? r_rollang : r_pitch;
        n_neg     = 1'b0;
        n_ang_red = {n_ang_sel[ANG_W-1], n_ang_sel};
        if (n_ang_sel > gctp_pkg::QUARTER) begin
            n_ang_red = n_ang_red - (ANG_W+1)'(32768);
            n_neg     = 1'b1;
        end else if (n_ang_sel < -gctp_pkg::QUARTER) begin
            n_ang_red = n_ang_red + (ANG_W+1)'(32768);
            n_neg     = 1'b1;
        end
        n_xs   = r_x >>> r_it;
        n_ys   = r_y >>> r_it;
        n_atan = gctp_pkg::atan_val(r_it);
        if (!r_z[CRD_W-1]) begin
            n_x = r_x - n_ys;
            n_y = r_y + n_xs;
            n_z = r_z - n_atan;
        end else begin
            n_x = r_x + n_ys;
            n_y = r_y - n_xs;
            n_z = r_z + n_atan;
        end
        n_xf = r_neg ? -n_x : n_x;
        n_yf = r_neg ? -n_y : n_y;
        n_grav1 = LIN_W'((n_yf + (CRD_W'(1) <<< 17)) >>> 18);
        n_rnd48 = (r_prod + (PROD_W'(1) <<< 47)) >>> 48;
        n_a1    = LIN_W'(r_acc[r_ax]) - r_grav[r_ax];
        n_asum  = (LIN_W+1)'(n_a1) + (LIN_W+1)'(r_last[r_ax]);
        n_rnd17 = (r_prod + (PROD_W'(1) <<< 16)) >>> 17;
        n_vsum  = (POS_W+2)'(r_vel[r_ax]) + (POS_W+2)'(n_rnd17);
        if (n_vsum > (POS_W+2)'(32'sh7fffffff))
            n_v1 = 32'sh7fffffff;
        else if (n_vsum < -(POS_W+2)'(33'sh080000000))
            n_v1 = 32'sh80000000;
        else
            n_v1 = POS_W'(n_vsum);
        n_vv    = (POS_W+1)'(n_v1) + (POS_W+1)'(r_vel[r_ax]);
        n_rnd21 = (r_prod + (PROD_W'(1) <<< 20)) >>> 21;
        n_psum  = (POS_W+2)'(r_prev[r_ax]) + (POS_W+2)'(n_rnd21);
        if (n_psum > (POS_W+2)'(32'sh7fffffff))
            n_p1 = 32'sh7fffffff;
        else if (n_psum < -(POS_W+2)'(33'sh080000000))
            n_p1 = 32'sh80000000;
        else
            n_p1 = POS_W'(n_psum);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_it     <= '0;
            r_roll   <= 1'b0;
            r_ax     <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_last[i] <= '0;
                r_vel[i]  <= '0;
            end
        end else begin
            if (r_ovalid && m_axis_tready && r_state != ST_OUT)
                r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_acc[0]  <= s_axis_tdata[15:0];
                        r_acc[1]  <= s_axis_tdata[31:16];
                        r_acc[2]  <= s_axis_tdata[47:32];
                        r_pitch   <= s_axis_tdata[63:48];
                        r_rollang <= s_axis_tdata[79:64];
                        r_prev[0] <= s_axis_tdata[111:80];
                        r_prev[1] <= s_axis_tdata[143:112];
                        r_prev[2] <= s_axis_tdata[175:144];
                        r_dt      <= s_axis_tdata[195:176];
                        r_roll    <= 1'b0;
                        r_it      <= '0;
                        r_x       <= gctp_pkg::CORDIC_K;
                        r_y       <= '0;
                        r_state   <= ST_RED;
                    end
                end
                ST_RED: begin
                    r_z     <= CRD_W'(n_ang_red) <<< 16;
                    r_neg   <= n_neg;
                    r_state <= ST_ROT;
                end
                ST_ROT: begin
                    if (r_it == LAST_IT) begin
                        if (!r_roll) begin
                            r_cp    <= MUL_W'(n_xf);
                            r_sp    <= MUL_W'(n_yf);
                            r_roll  <= 1'b1;
                            r_it    <= '0;
                            r_x     <= gctp_pkg::CORDIC_K;
                            r_y     <= '0;
                            r_state <= ST_RED;
                        end else begin
                            r_cr      <= MUL_W'(n_xf);
                            r_grav[1] <= n_grav1;
                            r_ma      <= MUL_W'(n_xf);
                            r_mb      <= r_sp;
                            r_state   <= ST_G0W;
                        end
                    end else begin
                        r_x  <= n_x;
                        r_y  <= n_y;
                        r_z  <= n_z;
                        r_it <= r_it + 1'b1;
                    end
                end
                ST_G0W: r_state <= ST_G0;
                ST_G0: begin
                    r_grav[0] <= LIN_W'(n_rnd48);
                    r_ma      <= r_cr;
                    r_mb      <= r_cp;
                    r_state   <= ST_G2W;
                end
                ST_G2W: r_state <= ST_G2;
                ST_G2: begin
                    r_grav[2] <= LIN_W'(n_rnd48);
                    r_ax      <= '0;
                    r_state   <= ST_VOP;
                end
                ST_VOP: begin
                    r_a1    <= n_a1;
                    r_ma    <= MUL_W'(n_asum);
                    r_mb    <= MUL_W'(r_dt);
                    r_state <= ST_VW;
                end
                ST_VW: r_state <= ST_V;
                ST_V: begin
                    r_v1    <= n_v1;
                    r_ma    <= MUL_W'(n_vv);
                    r_mb    <= MUL_W'(r_dt);
                    r_state <= ST_PW;
                end
                ST_PW: r_state <= ST_P;
                ST_P: begin
                    r_pos[r_ax]  <= n_p1;
                    r_last[r_ax] <= r_a1;
                    r_vel[r_ax]  <= r_v1;
                    if (r_ax == 2'd2) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= ST_VOP;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {r_pos[2], r_pos[1], r_pos[0]};
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input still ready after a transaction was accepted");

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_it <= LAST_IT)
        else $error("CORDIC iteration counter out of range");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ax != 2'd3)
        else $error("axis index out of range");
`endif

endmodule
